// ===== hw/rtl/rsa_pkg.sv =====
// shared types and constants for the running statistics accumulator
package rsa_pkg;

	localparam int FIELD_W       = 24;
	localparam int COUNT_FIELD_W = 16;
	localparam int M_DATA_W      = COUNT_FIELD_W + 4 * FIELD_W;
	localparam int M_USER_W      = 2;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [APB_ADDR_W-1:0] ADDR_HIST_EN = 3'd0;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_PREP,
		ST_MUL_SQ,
		ST_MUL_S,
		ST_DIV_CHK,
		ST_DIV_VAR,
		ST_SQRT_LD,
		ST_SQRT,
		ST_DEV_LD,
		ST_DIV_MEAN,
		ST_MEAN_LD,
		ST_CLEAR,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic load_in;
		logic square;
		logic accum;
		logic clear;
		logic mul_sq_start;
		logic mul_s_start;
		logic mul_step;
		logic div_var_start;
		logic div_mean_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic dev_load;
		logic dev_zero;
		logic mean_load;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic cnt_lt2;
		logic var_neg;
		logic iter_last;
	} sts_t;

endpackage

// ===== hw/rtl/rsa_ctrl.sv =====
// sequencer for the statistics datapath and the result handshake
module rsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_kind,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  rsa_pkg::sts_t sts,
	output rsa_pkg::cmd_t cmd
);
	import rsa_pkg::*;

	state_e state_q, state_d;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_kind == KIND_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (sts.full) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SQUARE;
					end
				end
			end
			ST_SQUARE:   state_d = ST_ACCUM;
			ST_ACCUM:    state_d = ST_PREP;
			ST_PREP:     state_d = sts.cnt_lt2 ? ST_DIV_MEAN : ST_MUL_SQ;
			ST_MUL_SQ:   if (sts.iter_last) state_d = ST_MUL_S;
			ST_MUL_S:    if (sts.iter_last) state_d = ST_DIV_CHK;
			ST_DIV_CHK:  state_d = sts.var_neg ? ST_DIV_MEAN : ST_DIV_VAR;
			ST_DIV_VAR:  if (sts.iter_last) state_d = ST_SQRT_LD;
			ST_SQRT_LD:  state_d = ST_SQRT;
			ST_SQRT:     if (sts.iter_last) state_d = ST_DEV_LD;
			ST_DEV_LD:   state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: if (sts.iter_last) state_d = ST_MEAN_LD;
			ST_MEAN_LD:  state_d = ST_DONE;
			ST_CLEAR:    state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load_in = accept;
			ST_SQUARE: cmd.square = 1'b1;
			ST_ACCUM:  cmd.accum = 1'b1;
			ST_PREP: begin
				// a single sample has no spread
				if (sts.cnt_lt2) begin
					cmd.dev_zero       = 1'b1;
					cmd.div_mean_start = 1'b1;
				end else begin
					cmd.mul_sq_start = 1'b1;
				end
			end
			ST_MUL_SQ: begin
				cmd.mul_step    = 1'b1;
				cmd.mul_s_start = sts.iter_last;
			end
			ST_MUL_S: cmd.mul_step = 1'b1;
			ST_DIV_CHK: begin
				if (sts.var_neg) begin
					cmd.dev_zero       = 1'b1;
					cmd.div_mean_start = 1'b1;
				end else begin
					cmd.div_var_start = 1'b1;
				end
			end
			ST_DIV_VAR: cmd.div_step = 1'b1;
			ST_SQRT_LD: cmd.sqrt_start = 1'b1;
			ST_SQRT:    cmd.sqrt_step = 1'b1;
			ST_DEV_LD: begin
				cmd.dev_load       = 1'b1;
				cmd.div_mean_start = 1'b1;
			end
			ST_DIV_MEAN: cmd.div_step = 1'b1;
			ST_MEAN_LD:  cmd.mean_load = 1'b1;
			ST_CLEAR:    cmd.clear = 1'b1;
			ST_DONE:     cmd.load_out = out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/rsa_dpath.sv =====
// statistics registers, shift-add multiplier, restoring divider and square root
module rsa_dpath #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsa_pkg::cmd_t                  cmd,
	output rsa_pkg::sts_t                  sts,
	input  logic                           hist_en,
	input  logic                           in_kind,
	input  logic [rsa_pkg::FIELD_W-1:0]    in_sample,
	output logic [rsa_pkg::M_DATA_W-1:0]   out_data,
	output logic [rsa_pkg::M_USER_W-1:0]   out_user
);
	import rsa_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
	localparam int SQS_W = COUNT_BITS + 2 * SAMPLE_BITS - 2;
	localparam int ACC_W = 2 * SUM_W;
	localparam int DVD_W = 2 * SUM_W - 2;
	localparam int DV_W  = 2 * COUNT_BITS;
	localparam int Q_W   = 2 * SAMPLE_BITS;
	localparam int IT_W  = $clog2(DVD_W + 1);

	// statistics
	logic [COUNT_BITS-1:0]         count_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQS_W-1:0]              sumsq_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q, mean_q;
	logic [SAMPLE_BITS-1:0]        dev_q;

	// item and sequencing
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [SQ_W-1:0]               sq_q;
	logic                          sat_q;
	logic [IT_W-1:0]               it_q;

	// multiplier, divider, square root
	logic [ACC_W-1:0]  acc_q, mcand_q;
	logic [SUM_W-1:0]  mplier_q;
	logic              sub_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DV_W-1:0]   rem_q, dsr_q;
	logic [Q_W-1:0]    quo_q;
	logic [Q_W-1:0]    x_q, res_q, bit_q;

	logic [M_DATA_W-1:0] out_data_q;
	logic [M_USER_W-1:0] out_user_q;

	logic signed [2*SAMPLE_BITS-1:0] prod;
	logic [SUM_W-1:0]                sum_mag;
	logic [DV_W-1:0]                 npair;
	logic [DV_W:0]                   r2;
	logic                            ge;
	logic [Q_W:0]                    trial;
	logic                            fits;
	logic [SAMPLE_BITS-1:0]          qlo;
	logic                            ev;
	logic [FIELD_W-1:0]              min_f, max_f;

	assign prod    = smp_q * smp_q;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign npair   = DV_W'(count_q) * DV_W'(count_q - 1'b1);
	assign r2      = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (r2 >= {1'b0, dsr_q});
	assign trial   = {1'b0, res_q} + {1'b0, bit_q};
	assign fits    = ({1'b0, x_q} >= trial);
	assign qlo     = quo_q[SAMPLE_BITS-1:0];

	assign ev    = hist_en && (count_q != '0);
	assign min_f = ev ? FIELD_W'(min_q) : '1;
	assign max_f = ev ? FIELD_W'(max_q) : '1;

	assign sts.full      = &count_q;
	assign sts.cnt_lt2   = (count_q < COUNT_BITS'(2));
	assign sts.var_neg   = acc_q[ACC_W-1];
	assign sts.iter_last = (it_q == IT_W'(1));

	assign out_data = out_data_q;
	assign out_user = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			dev_q   <= '0;
			mean_q  <= '0;
			it_q    <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
				dev_q   <= '0;
				mean_q  <= '0;
			end
			if (cmd.accum) begin
				if (count_q == '0) begin
					min_q <= smp_q;
					max_q <= smp_q;
				end else begin
					if (smp_q < min_q) min_q <= smp_q;
					if (smp_q > max_q) max_q <= smp_q;
				end
				sum_q   <= sum_q + SUM_W'(smp_q);
				sumsq_q <= sumsq_q + SQS_W'(sq_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.dev_zero) begin
				dev_q <= '0;
			end else if (cmd.dev_load) begin
				dev_q <= res_q[SAMPLE_BITS-1:0];
			end
			if (cmd.mean_load) begin
				mean_q <= sum_q[SUM_W-1] ? $signed(-qlo) : $signed(qlo);
			end

			if (cmd.mul_sq_start) begin
				it_q <= IT_W'(COUNT_BITS);
			end else if (cmd.mul_s_start || cmd.div_mean_start) begin
				it_q <= IT_W'(SUM_W);
			end else if (cmd.div_var_start) begin
				it_q <= IT_W'(DVD_W);
			end else if (cmd.sqrt_start) begin
				it_q <= IT_W'(SAMPLE_BITS);
			end else if (cmd.mul_step || cmd.div_step || cmd.sqrt_step) begin
				it_q <= it_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			smp_q <= $signed(in_sample[SAMPLE_BITS-1:0]);
			sat_q <= (in_kind == KIND_SAMPLE) && (&count_q);
		end
		if (cmd.square) begin
			sq_q <= prod[SQ_W-1:0];
		end

		// n * sum of squares, then minus sum squared, in modular arithmetic
		if (cmd.mul_sq_start) begin
			acc_q    <= '0;
			mcand_q  <= ACC_W'(sumsq_q);
			mplier_q <= SUM_W'(count_q);
			sub_q    <= 1'b0;
		end else if (cmd.mul_s_start) begin
			mcand_q  <= ACC_W'(sum_mag);
			mplier_q <= sum_mag;
			sub_q    <= 1'b1;
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) acc_q <= sub_q ? acc_q - mcand_q : acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end

		if (cmd.div_var_start) begin
			dvd_q <= acc_q[DVD_W-1:0];
			dsr_q <= npair;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_mean_start) begin
			dvd_q <= DVD_W'(sum_mag) << (DVD_W - SUM_W);
			dsr_q <= DV_W'(count_q);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? DV_W'(r2 - {1'b0, dsr_q}) : r2[DV_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
			dvd_q <= dvd_q << 1;
		end

		if (cmd.sqrt_start) begin
			x_q   <= quo_q;
			res_q <= '0;
			bit_q <= Q_W'(1) << (Q_W - 2);
		end else if (cmd.sqrt_step) begin
			if (fits) begin
				x_q   <= x_q - trial[Q_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.load_out) begin
			out_data_q <= {max_f, min_f, FIELD_W'(dev_q), FIELD_W'(mean_q),
				COUNT_FIELD_W'(count_q)};
			out_user_q <= {sat_q, ev};
		end
	end

endmodule

// ===== hw/rtl/running_statistics_accumulator_unit.sv =====
// running count, mean, sample deviation and extremes over a sample stream
// a sample's mean and deviation are worked out by a bit-serial multiply, divide and square root
// a clear and a dropped sample skip the arithmetic; a first sample skips the multiply and square root
// one item in flight; a new item is taken only once the previous result has been passed to the output
// reset: all statistics zero, history enable set, no result pending
module running_statistics_accumulator_unit #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rsa_pkg::FIELD_W-1:0]      s_tdata,  // sample
	input  logic [0:0]                       s_tuser,  // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// sample_count, mean_value, std_deviation, minimum_value, maximum_value
	output logic [rsa_pkg::M_DATA_W-1:0]     m_tdata,
	output logic [rsa_pkg::M_USER_W-1:0]     m_tuser,  // extremes_valid, saturated
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rsa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rsa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rsa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import rsa_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic hist_en_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_HIST_EN) ? APB_DATA_W'(hist_en_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_HIST_EN) begin
			hist_en_q <= pwdata[0];
		end
	end

	rsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_kind   (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsa_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.hist_en   (hist_en_q),
		.in_kind   (s_tuser[0]),
		.in_sample (s_tdata),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
